[src/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag any clock edge at which cond holds.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Require cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/lzfc_pkg.sv]
// Shared types and constants of the fill/copy LZ decoder.
`default_nettype none
package lzfc_pkg;

   localparam int unsigned HIST_ADDR_BITS_DEF = 16;
   localparam int unsigned QUEUE_DEPTH        = 2;
   localparam int unsigned PTR_BITS           = 16;
   localparam int unsigned COUNT_BITS         = 11;

   typedef enum logic [2:0] {
      PH_CMD,
      PH_LONGLEN,
      PH_ARG1,
      PH_ARG2,
      PH_COPY,
      PH_EMIT
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_END,
      ST_ERR,
      ST_TURN
   } status_type;

   localparam logic [2:0] KIND_COPY   = 3'd0;
   localparam logic [2:0] KIND_FILL   = 3'd1;
   localparam logic [2:0] KIND_ALT    = 3'd2;
   localparam logic [2:0] KIND_INC    = 3'd3;
   localparam logic [2:0] KIND_REPEAT = 3'd4;

   localparam logic [2:0] LONG_TAG = 3'b111;
   localparam logic [7:0] END_CMD  = 8'hFF;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       want_byte;
      status_type status;
      logic       from_history;
   } desc_type;

endpackage
`default_nettype wire

[src/lzfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzfc_ram #(
   parameter int unsigned DATA_BITS = 8,
   parameter int unsigned DEPTH     = 256
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  wire logic [DATA_BITS-1:0]         wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic      [DATA_BITS-1:0]         rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/lzfc_queue.sv]
// Short register queue between the parser and the executor.
`default_nettype none
`include "assert_macros.svh"
module lzfc_queue import lzfc_pkg::*; #(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int unsigned IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [IDX_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full, "queue push while full")
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !not_empty, "queue pop while empty")

endmodule
`default_nettype wire

[src/lzfc_front.sv]
// Command parser: classifies each beat and tracks the decode state.
`default_nettype none
`include "assert_macros.svh"
module lzfc_front import lzfc_pkg::*; #(
   parameter int unsigned HISTORY_ADDR_BITS = HIST_ADDR_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         action,
   input  wire logic [7:0]                   comp_byte,
   output desc_type                          push_desc,
   output logic      [HISTORY_ADDR_BITS-1:0] push_rd_addr,
   output logic      [HISTORY_ADDR_BITS-1:0] push_wr_addr
);

   localparam int unsigned AW = HISTORY_ADDR_BITS;

   phase_type             phase_ff, phase_in;
   logic [2:0]            kind_ff, kind_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [7:0]            first_ff, first_in;
   logic [7:0]            second_ff, second_in;
   logic                  toggle_ff, toggle_in;
   logic [AW-1:0]         rp_ff, rp_in;
   logic [AW-1:0]         wp_ff, wp_in;
   status_type            fin_ff, fin_in;

   logic                  wants;
   logic                  long_hdr;
   logic [2:0]            hdr_kind;
   logic [PTR_BITS-1:0]   ptr_hi;
   logic [PTR_BITS-1:0]   ptr_lo;
   logic                  last_byte;
   desc_type              desc;

   assign wants     = (phase_ff != PH_EMIT);
   assign long_hdr  = (comp_byte[7:5] == LONG_TAG);
   assign hdr_kind  = long_hdr ? comp_byte[4:2] : comp_byte[7:5];
   assign ptr_hi    = {comp_byte, 8'h00};
   assign ptr_lo    = {8'h00, comp_byte};
   assign last_byte = (rem_ff == COUNT_BITS'(1));

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      rem_in    = rem_ff;
      first_in  = first_ff;
      second_in = second_ff;
      toggle_in = toggle_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      fin_in    = fin_ff;

      desc.out_valid    = 1'b0;
      desc.out_byte     = 8'h00;
      desc.want_byte    = 1'b0;
      desc.status       = ST_RUN;
      desc.from_history = 1'b0;

      if (fin_ff != ST_RUN) begin
         desc.status = fin_ff;
      end else if ((action == ACT_BYTE) != wants) begin
         desc.status    = ST_TURN;
         desc.want_byte = wants;
      end else begin
         if (action == ACT_BYTE) begin
            unique case (phase_ff)
               PH_CMD: begin
                  if (comp_byte == END_CMD) begin
                     fin_in = ST_END;
                  end else if (hdr_kind > KIND_REPEAT) begin
                     fin_in = ST_ERR;
                  end else begin
                     kind_in = hdr_kind;
                     if (long_hdr) begin
                        rem_in   = {1'b0, comp_byte[1:0], 8'h00};
                        phase_in = PH_LONGLEN;
                     end else begin
                        rem_in   = COUNT_BITS'(comp_byte[4:0]) + COUNT_BITS'(1);
                        phase_in = (hdr_kind == KIND_COPY) ? PH_COPY : PH_ARG1;
                     end
                  end
               end
               PH_LONGLEN: begin
                  rem_in   = rem_ff + COUNT_BITS'(comp_byte) + COUNT_BITS'(1);
                  phase_in = (kind_ff == KIND_COPY) ? PH_COPY : PH_ARG1;
               end
               PH_ARG1: begin
                  toggle_in = 1'b0;
                  if (kind_ff == KIND_REPEAT) begin
                     rp_in    = ptr_hi[AW-1:0];
                     phase_in = PH_ARG2;
                  end else begin
                     first_in = comp_byte;
                     phase_in = (kind_ff == KIND_ALT) ? PH_ARG2 : PH_EMIT;
                  end
               end
               PH_ARG2: begin
                  if (kind_ff == KIND_REPEAT) begin
                     rp_in = rp_ff | ptr_lo[AW-1:0];
                  end else begin
                     second_in = comp_byte;
                  end
                  phase_in = PH_EMIT;
               end
               PH_COPY: begin
                  desc.out_valid = 1'b1;
                  desc.out_byte  = comp_byte;
                  wp_in          = wp_ff + AW'(1);
                  rem_in         = rem_ff - COUNT_BITS'(1);
                  if (last_byte) begin
                     phase_in = PH_CMD;
                  end
               end
               default: begin
                  phase_in = PH_CMD;
               end
            endcase
         end else begin
            desc.out_valid = 1'b1;
            unique case (kind_ff)
               KIND_FILL: begin
                  desc.out_byte = first_ff;
               end
               KIND_ALT: begin
                  desc.out_byte = toggle_ff ? second_ff : first_ff;
                  toggle_in     = !toggle_ff;
               end
               KIND_INC: begin
                  desc.out_byte = first_ff;
                  first_in      = first_ff + 8'd1;
               end
               default: begin
                  desc.from_history = 1'b1;
                  rp_in             = rp_ff + AW'(1);
               end
            endcase
            wp_in  = wp_ff + AW'(1);
            rem_in = rem_ff - COUNT_BITS'(1);
            if (last_byte) begin
               phase_in = PH_CMD;
            end
         end
         desc.status    = fin_in;
         desc.want_byte = (fin_in == ST_RUN) && (phase_in != PH_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CMD;
         kind_ff   <= '0;
         rem_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         toggle_ff <= 1'b0;
         rp_ff     <= '0;
         wp_ff     <= '0;
         fin_ff    <= ST_RUN;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         rem_ff    <= rem_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         toggle_ff <= toggle_in;
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         fin_ff    <= fin_in;
      end
   end

   assign push_desc    = desc;
   assign push_rd_addr = rp_ff;
   assign push_wr_addr = wp_ff;

   `ASSERT_NEXT(a_final_sticky, clock, reset, fin_ff != ST_RUN, fin_ff == $past(fin_ff), "end or error state left")

endmodule
`default_nettype wire

[src/lzfc_back.sv]
// Executor: history read with forwarding, history write and output register.
`default_nettype none
`include "assert_macros.svh"
module lzfc_back import lzfc_pkg::*; #(
   parameter int unsigned HISTORY_ADDR_BITS = HIST_ADDR_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   output logic                              q_pop,
   input  wire desc_type                     q_desc,
   input  wire logic [HISTORY_ADDR_BITS-1:0] q_rd_addr,
   input  wire logic [HISTORY_ADDR_BITS-1:0] q_wr_addr,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_out_valid,
   output logic      [7:0]                   rsp_out_byte,
   output logic                              rsp_want_byte,
   output logic      [1:0]                   rsp_status
);

   localparam int unsigned AW    = HISTORY_ADDR_BITS;
   localparam int unsigned DEPTH = 1 << AW;

   logic          s1_valid_ff, s1_valid_in;
   desc_type      s1_desc_ff;
   logic [AW-1:0] s1_wr_addr_ff;
   logic          s1_hit_ff;
   logic [7:0]    s1_fwd_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   desc_type      rsp_desc_ff;

   logic          out_free;
   logic          s1_adv;
   logic          wr_en;
   logic [7:0]    rd_data;
   logic [7:0]    s1_byte;
   logic          hit_in;
   desc_type      s1_result;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_adv   = s1_valid_ff && out_free;
   assign q_pop    = q_valid && (!s1_valid_ff || out_free);
   assign wr_en    = s1_adv && s1_desc_ff.out_valid;
   assign s1_byte  = !s1_desc_ff.from_history ? s1_desc_ff.out_byte
                   : (s1_hit_ff ? s1_fwd_ff : rd_data);
   assign hit_in   = wr_en && (s1_wr_addr_ff == q_rd_addr);

   always_comb begin
      s1_result          = s1_desc_ff;
      s1_result.out_byte = s1_byte;
   end

   lzfc_ram #(
      .DATA_BITS (8),
      .DEPTH     (DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_wr_addr_ff),
      .wr_data (s1_byte),
      .rd_en   (q_pop),
      .rd_addr (q_rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_desc_ff    <= q_desc;
         s1_wr_addr_ff <= q_wr_addr;
         s1_hit_ff     <= hit_in;
         s1_fwd_ff     <= s1_byte;
      end
      if (s1_adv) begin
         rsp_desc_ff <= s1_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_valid = rsp_desc_ff.out_valid;
   assign rsp_out_byte  = rsp_desc_ff.out_byte;
   assign rsp_want_byte = rsp_desc_ff.want_byte;
   assign rsp_status    = rsp_desc_ff.status;

   `ASSERT_NEXT(a_write_then_show, clock, reset, wr_en, rsp_valid_ff && rsp_desc_ff.out_valid, "written byte not presented")
   `ASSERT_NEVER(a_pop_into_busy, clock, reset, q_pop && s1_valid_ff && !out_free, "stage overwritten while stalled")

endmodule
`default_nettype wire

[src/lz_fill_copy_decoder.sv]
// Top level of the streaming fill/copy LZ decoder.
// Input channel req_*: each beat is either a compressed byte (req_action 0)
// or a tick asking for one output byte (req_action 1). Every accepted beat
// yields exactly one beat on the result channel rsp_*, in order, carrying an
// optional decoded byte, the want-byte flag and the decode status.
// A parser takes one beat per cycle while req_ready is high and classifies
// it; a two-entry queue feeds the executor, which reads the history RAM,
// forwards the byte written in the same cycle, writes the decoded byte and
// fills the output register. Throughput: one beat per cycle sustained while
// rsp_ready is high, set by the single history RAM port pair (one read and
// one write each cycle).
// Reset clears the parser and the valid flags; the history RAM is not
// cleared, so a repeat must only reach bytes already decoded.
// When rsp_ready is low the output register and executor stage hold, the
// queue fills, and req_ready drops once both queue entries are taken.
`default_nettype none
module lz_fill_copy_decoder import lzfc_pkg::*; #(
   parameter int unsigned HISTORY_ADDR_BITS = HIST_ADDR_BITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_action,
   input  wire logic [7:0] req_comp_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_out_valid,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_want_byte,
   output logic      [1:0] rsp_status
);

   localparam int unsigned AW     = HISTORY_ADDR_BITS;
   localparam int unsigned Q_BITS = $bits(desc_type) + 2 * AW;

   logic              accept;
   desc_type          push_desc;
   logic [AW-1:0]     push_rd_addr;
   logic [AW-1:0]     push_wr_addr;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   logic [Q_BITS-1:0] q_pop_data;
   desc_type          q_desc;
   logic [AW-1:0]     q_rd_addr;
   logic [AW-1:0]     q_wr_addr;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   lzfc_front #(
      .HISTORY_ADDR_BITS (AW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_action),
      .comp_byte    (req_comp_byte),
      .push_desc    (push_desc),
      .push_rd_addr (push_rd_addr),
      .push_wr_addr (push_wr_addr)
   );

   lzfc_queue #(
      .WIDTH (Q_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({push_desc, push_rd_addr, push_wr_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   assign {q_desc, q_rd_addr, q_wr_addr} = q_pop_data;

   lzfc_back #(
      .HISTORY_ADDR_BITS (AW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_pop         (q_pop),
      .q_desc        (q_desc),
      .q_rd_addr     (q_rd_addr),
      .q_wr_addr     (q_wr_addr),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_want_byte (rsp_want_byte),
      .rsp_status    (rsp_status)
   );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for the fill/copy LZ decoder with a built-in decode predictor.
`default_nettype none
module tb_top;
   import lzfc_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NOISE_PCT      = 4;
   localparam int CHUNK_ITEMS    = 120;

   typedef struct {
      logic       act;
      logic [7:0] b;
   } beat_in_type;

   typedef struct {
      logic       ov;
      logic [7:0] ob;
      logic       wb;
      status_type st;
   } beat_out_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_action    = ACT_BYTE;
   logic [7:0] req_comp_byte = 8'h00;
   logic       rsp_ready     = 1'b0;
   wire        req_ready;
   wire        rsp_valid;
   wire        rsp_out_valid;
   wire  [7:0] rsp_out_byte;
   wire        rsp_want_byte;
   wire  [1:0] rsp_status;

   lz_fill_copy_decoder uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_comp_byte (req_comp_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_want_byte (rsp_want_byte),
      .rsp_status    (rsp_status)
   );

   always #5 clock = ~clock;

   beat_in_type  stim_q[$];
   beat_out_type rsp_due[$];

   // decoder shadow state
   logic [7:0]  hist_mem [0:65535];
   logic [15:0] wr_pos    = '0;
   phase_type   dphase    = PH_CMD;
   logic [2:0]  cur_kind  = KIND_COPY;
   logic [10:0] left_cnt  = '0;
   logic [7:0]  fill_a    = '0;
   logic [7:0]  fill_b    = '0;
   logic        alt_sel   = 1'b0;
   logic [15:0] rep_ptr   = '0;
   status_type  dec_state = ST_RUN;

   int gen_count = 0;
   int out_total = 0;
   int noise_pct = 0;
   int send_idle = 0;
   int rsp_stall = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mism_cnt  = 0;
   int idle_cyc  = 0;

   task hist_put(input logic [7:0] b);
      hist_mem[wr_pos] = b;
      wr_pos = wr_pos + 16'd1;
      left_cnt = left_cnt - 11'd1;
      if (left_cnt == 11'd0) begin
         dphase = PH_CMD;
      end
   endtask

   task decode_beat(input logic act, input logic [7:0] b);
      beat_out_type r;
      logic [2:0]   k;
      r.ov = 1'b0;
      r.ob = 8'h00;
      r.wb = (dphase != PH_EMIT);
      if (dec_state != ST_RUN) begin
         r.st = dec_state;
         r.wb = 1'b0;
      end else if ((act == ACT_BYTE) != r.wb) begin
         r.st = ST_TURN;
      end else begin
         if (act == ACT_BYTE) begin
            case (dphase)
               PH_CMD: begin
                  if (b == END_CMD) begin
                     dec_state = ST_END;
                  end else begin
                     if (b[7:5] == LONG_TAG) begin
                        k = b[4:2];
                        left_cnt = {1'b0, b[1:0], 8'h00};
                        dphase = PH_LONGLEN;
                     end else begin
                        k = b[7:5];
                        left_cnt = {6'd0, b[4:0]} + 11'd1;
                     end
                     if (k > KIND_REPEAT) begin
                        dec_state = ST_ERR;
                     end else begin
                        cur_kind = k;
                        if (dphase == PH_CMD) begin
                           dphase = (k == KIND_COPY) ? PH_COPY : PH_ARG1;
                        end
                     end
                  end
               end
               PH_LONGLEN: begin
                  left_cnt = left_cnt + {3'd0, b} + 11'd1;
                  dphase = (cur_kind == KIND_COPY) ? PH_COPY : PH_ARG1;
               end
               PH_ARG1: begin
                  alt_sel = 1'b0;
                  if (cur_kind == KIND_REPEAT) begin
                     rep_ptr = {b, 8'h00};
                     dphase = PH_ARG2;
                  end else begin
                     fill_a = b;
                     dphase = (cur_kind == KIND_ALT) ? PH_ARG2 : PH_EMIT;
                  end
               end
               PH_ARG2: begin
                  if (cur_kind == KIND_REPEAT) begin
                     rep_ptr[7:0] = b;
                  end else begin
                     fill_b = b;
                  end
                  dphase = PH_EMIT;
               end
               PH_COPY: begin
                  r.ov = 1'b1;
                  r.ob = b;
                  hist_put(b);
               end
               default: begin
                  dphase = PH_CMD;
               end
            endcase
         end else begin
            case (cur_kind)
               KIND_FILL: begin
                  r.ob = fill_a;
               end
               KIND_ALT: begin
                  r.ob = alt_sel ? fill_b : fill_a;
                  alt_sel = ~alt_sel;
               end
               KIND_INC: begin
                  r.ob = fill_a;
                  fill_a = fill_a + 8'd1;
               end
               default: begin
                  r.ob = hist_mem[rep_ptr];
                  rep_ptr = rep_ptr + 16'd1;
               end
            endcase
            r.ov = 1'b1;
            hist_put(r.ob);
         end
         r.st = dec_state;
         r.wb = (dec_state == ST_RUN) && (dphase != PH_EMIT);
      end
      rsp_due.push_back(r);
   endtask

   task put_item(input logic act, input logic [7:0] b);
      beat_in_type s;
      if ($urandom_range(0, 99) < noise_pct) begin
         s.act = ~act;
         s.b = 8'($urandom_range(0, 255));
         stim_q.push_back(s);
         gen_count++;
      end
      s.act = act;
      s.b = b;
      stim_q.push_back(s);
      gen_count++;
   endtask

   task gen_command(input logic [2:0] kind, input int len, input logic long_hdr);
      logic [9:0]  n1;
      logic [15:0] p;
      int          i;
      n1 = 10'(len - 1);
      if (long_hdr) begin
         put_item(ACT_BYTE, {LONG_TAG, kind, n1[9:8]});
         put_item(ACT_BYTE, n1[7:0]);
      end else begin
         put_item(ACT_BYTE, {kind, n1[4:0]});
      end
      case (kind)
         KIND_COPY: begin
            for (i = 0; i < len; i++) begin
               put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
         end
         KIND_REPEAT: begin
            p = 16'($urandom_range(0, out_total - 1));
            put_item(ACT_BYTE, p[15:8]);
            put_item(ACT_BYTE, p[7:0]);
         end
         default: begin
            put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            if (kind == KIND_ALT) begin
               put_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
         end
      endcase
      if (kind != KIND_COPY) begin
         for (i = 0; i < len; i++) begin
            put_item(ACT_TICK, 8'($urandom_range(0, 255)));
         end
      end
      out_total += len;
   endtask

   task gen_chunk(input int n);
      int         target;
      logic [2:0] kind;
      logic       lh;
      int         len;
      target = gen_count + n;
      while (gen_count < target) begin
         kind = 3'($urandom_range(32'(KIND_COPY), 32'(KIND_REPEAT)));
         lh = ($urandom_range(0, 99) < 20);
         if (lh) begin
            len = $urandom_range(1, 80);
         end else if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 32);
         end else begin
            len = $urandom_range(1, 8);
         end
         gen_command(kind, len, lh);
      end
   endtask

   task drain_all;
      while (stim_q.size() != 0 || req_valid || rsp_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : driver_proc
      beat_in_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_beat(req_action, req_comp_byte);
         end
         if (!req_valid || req_ready) begin
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               s = stim_q.pop_front();
               req_valid     <= 1'b1;
               req_action    <= s.act;
               req_comp_byte <= s.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor_proc
      beat_out_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               mism_cnt++;
               if (mism_cnt <= 10) begin
                  $display("unexpected beat: ov=%0d ob=%02h wb=%0d st=%0d",
                           rsp_out_valid, rsp_out_byte, rsp_want_byte, rsp_status);
               end
            end else begin
               w = rsp_due.pop_front();
               if (rsp_out_valid !== w.ov || rsp_out_byte !== w.ob ||
                   rsp_want_byte !== w.wb || rsp_status !== w.st) begin
                  mism_cnt++;
                  if (mism_cnt <= 10) begin
                     $display("mismatch: got %0d %02h %0d %0d want %0d %02h %0d %0d",
                              rsp_out_valid, rsp_out_byte, rsp_want_byte, rsp_status,
                              w.ov, w.ob, w.wb, w.st);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_seen + 1;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cyc <= 0;
      end else if (idle_cyc >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cyc <= idle_cyc + 1;
      end
   end

   initial begin
      int         i;
      logic [7:0] last_cmd;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // tick while a command byte is wanted
      put_item(ACT_TICK, 8'h00);
      // copy of both extreme literals
      put_item(ACT_BYTE, {KIND_COPY, 5'd1});
      put_item(ACT_BYTE, 8'h00);
      put_item(ACT_BYTE, 8'hFF);
      // byte fill with a byte offered while a tick is wanted
      put_item(ACT_BYTE, {KIND_FILL, 5'd1});
      put_item(ACT_BYTE, 8'hA5);
      put_item(ACT_TICK, 8'h00);
      put_item(ACT_BYTE, 8'h5A);
      put_item(ACT_TICK, 8'h00);
      // alternating word fill
      put_item(ACT_BYTE, {KIND_ALT, 5'd2});
      put_item(ACT_BYTE, 8'h12);
      put_item(ACT_BYTE, 8'h34);
      repeat (3) put_item(ACT_TICK, 8'h00);
      // incrementing fill wrapping past 255
      put_item(ACT_BYTE, {KIND_INC, 5'd1});
      put_item(ACT_BYTE, 8'hFF);
      repeat (2) put_item(ACT_TICK, 8'h00);
      // long-header repeat from offset zero
      put_item(ACT_BYTE, {LONG_TAG, KIND_REPEAT, 2'b00});
      put_item(ACT_BYTE, 8'h02);
      put_item(ACT_BYTE, 8'h00);
      put_item(ACT_BYTE, 8'h00);
      repeat (3) put_item(ACT_TICK, 8'h00);
      out_total = 12;
      drain_all;

      noise_pct = NOISE_PCT;
      gen_command(KIND_INC, 1024, 1'b1);
      gen_chunk(CHUNK_ITEMS);
      drain_all;

      send_idle = 58;
      rsp_stall = 0;
      gen_chunk(CHUNK_ITEMS);
      drain_all;

      send_idle = 0;
      rsp_stall = 58;
      gen_chunk(CHUNK_ITEMS);
      drain_all;

      send_idle = 7;
      rsp_stall = 7;
      gen_chunk(CHUNK_ITEMS);
      drain_all;

      // hold the receiver off while the sender keeps offering beats
      send_idle = 0;
      rsp_stall = 0;
      hold_reqs++;
      gen_chunk(100);
      drain_all;

      // terminate with an end marker or an unused command, then feed dead beats
      noise_pct = 0;
      case ($urandom_range(0, 2))
         0: last_cmd = END_CMD;
         1: last_cmd = 8'($urandom_range(8'hA0, 8'hDF));
         default: last_cmd = 8'($urandom_range(8'hF4, 8'hFE));
      endcase
      put_item(ACT_BYTE, last_cmd);
      for (i = 0; i < 6; i++) begin
         put_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      drain_all;

      repeat (8) @(posedge clock);
      if (mism_cnt == 0 && rsp_due.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
